// ----- sv/cbl_pkg.sv -----
`timescale 1ns / 1ps

package cbl_pkg;

    localparam int COEF_W     = 32;
    localparam int PAIR_W     = 64;
    localparam int PROD_W     = 64;
    localparam int Q_SHIFT    = 28;
    localparam int RND_W      = PROD_W - Q_SHIFT;
    localparam int ACC_W      = 38;
    localparam int REG_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_GAIN         = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FIRST_POLES  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FIRST_ZEROS  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SECOND_POLES = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SECOND_ZEROS = 3'd4;

    localparam logic [COEF_W-1:0] GAIN_RESET = 32'h1000_0000;

    typedef logic [2:0] t_op;
    localparam t_op OP_GAIN = 3'd0;
    localparam t_op OP_B1   = 3'd1;
    localparam t_op OP_B2   = 3'd2;
    localparam t_op OP_A1   = 3'd3;
    localparam t_op OP_A2   = 3'd4;

    typedef logic [1:0] t_sect;

    typedef struct packed {
        logic [COEF_W-1:0] gain;
        logic [PAIR_W-1:0] first_poles;
        logic [PAIR_W-1:0] first_zeros;
        logic [PAIR_W-1:0] second_poles;
        logic [PAIR_W-1:0] second_zeros;
    } t_coefs;

    typedef struct packed {
        logic  load_sample;
        logic  issue;
        t_op   op;
        t_sect sect;
        logic  out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_full;
    } t_dp_stat;

    function automatic logic signed [COEF_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-COEF_W:0] top;
        top = v[ACC_W-1:COEF_W-1];
        if ((&top) || !(|top)) begin
            return v[COEF_W-1:0];
        end else if (v[ACC_W-1]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7fff_ffff;
        end
    endfunction

endpackage

// ----- sv/cbl_regs.sv -----
`timescale 1ns / 1ps

module cbl_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cbl_pkg::REG_ADDR_W-1:0]   paddr,
    input  logic [cbl_pkg::PAIR_W-1:0]       pwdata,
    output logic [cbl_pkg::PAIR_W-1:0]       prdata,
    output logic                             pready,
    output cbl_pkg::t_coefs                  o_coefs
);
    import cbl_pkg::*;

    logic [COEF_W-1:0]    r_gain;
    logic [PAIR_W-1:0]    r_first_poles;
    logic [PAIR_W-1:0]    r_first_zeros;
    logic [PAIR_W-1:0]    r_second_poles;
    logic [PAIR_W-1:0]    r_second_zeros;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[REG_ADDR_W-1:REG_ADDR_W-REG_IDX_W];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain         <= GAIN_RESET;
            r_first_poles  <= '0;
            r_first_zeros  <= '0;
            r_second_poles <= '0;
            r_second_zeros <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_GAIN:         r_gain         <= pwdata[COEF_W-1:0];
                REG_FIRST_POLES:  r_first_poles  <= pwdata;
                REG_FIRST_ZEROS:  r_first_zeros  <= pwdata;
                REG_SECOND_POLES: r_second_poles <= pwdata;
                REG_SECOND_ZEROS: r_second_zeros <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_GAIN:         prdata = PAIR_W'(r_gain);
            REG_FIRST_POLES:  prdata = r_first_poles;
            REG_FIRST_ZEROS:  prdata = r_first_zeros;
            REG_SECOND_POLES: prdata = r_second_poles;
            REG_SECOND_ZEROS: prdata = r_second_zeros;
            default:          prdata = '0;
        endcase
    end

    assign o_coefs.gain         = r_gain;
    assign o_coefs.first_poles  = r_first_poles;
    assign o_coefs.first_zeros  = r_first_zeros;
    assign o_coefs.second_poles = r_second_poles;
    assign o_coefs.second_zeros = r_second_zeros;

endmodule

// ----- sv/cbl_ctrl.sv -----
`timescale 1ns / 1ps

module cbl_ctrl #(
    parameter int SECTIONS = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cbl_pkg::t_dp_stat  i_stat,
    output cbl_pkg::t_dp_cmd   o_cmd
);
    import cbl_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    localparam t_sect LAST_SECT = t_sect'(SECTIONS - 1);

    logic [1:0] r_state, n_state;
    t_op        r_op, n_op;
    t_sect      r_sect, n_sect;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_GAIN;
            r_sect  <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_sect  <= n_sect;
        end
    end

    always_comb begin
        n_state           = r_state;
        n_op              = r_op;
        n_sect            = r_sect;
        o_in_ready        = 1'b0;
        o_cmd.load_sample = 1'b0;
        o_cmd.issue       = 1'b0;
        o_cmd.op          = r_op;
        o_cmd.sect        = r_sect;
        o_cmd.out_load    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_sample = 1'b1;
                    n_op              = OP_GAIN;
                    n_sect            = '0;
                    n_state           = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                if (r_op == OP_GAIN) begin
                    n_op = OP_B1;
                end else if (r_op == OP_A2) begin
                    n_op = OP_B1;
                    if (r_sect == LAST_SECT) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_sect = r_sect + 1'b1;
                    end
                end else begin
                    n_op = r_op + 1'b1;
                end
            end
            S_FLUSH: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
        endcase
    end

endmodule

// ----- sv/cbl_dpath.sv -----
`timescale 1ns / 1ps

module cbl_dpath #(
    parameter int SECTIONS    = 2,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cbl_pkg::t_coefs               i_coefs,
    input  cbl_pkg::t_dp_cmd              i_cmd,
    output cbl_pkg::t_dp_stat             o_stat,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic                          o_out_valid,
    input  logic                          i_out_ready
);
    import cbl_pkg::*;

    localparam logic signed [ACC_W-1:0] SMP_MAX =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SMP_MIN = ~SMP_MAX;
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(64'sd1 <<< (Q_SHIFT - 1));

    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic signed [PROD_W-1:0]      r_prod;
    logic                          r_pend_valid;
    t_op                           r_pend_op;
    t_sect                         r_pend_sect;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [COEF_W-1:0]      r_h1 [SECTIONS];
    logic signed [COEF_W-1:0]      r_h2 [SECTIONS];
    logic signed [SAMPLE_BITS-1:0] r_out;
    logic                          r_out_valid;

    logic signed [COEF_W-1:0]      h1_sel, h2_sel;
    logic [PAIR_W-1:0]             poles_sel, zeros_sel;
    logic signed [COEF_W-1:0]      mul_a, mul_b;
    logic signed [PROD_W-1:0]      prod;
    logic signed [PROD_W-1:0]      rnd_sum;
    logic signed [ACC_W-1:0]       rnd_ext;
    logic signed [COEF_W-1:0]      acc_sat;
    logic signed [ACC_W-1:0]       base;
    logic                          sub;
    logic signed [ACC_W-1:0]       acc_sum;
    logic signed [SAMPLE_BITS-1:0] out_clip;

    // operand select
    always_comb begin
        h1_sel = '0;
        h2_sel = '0;
        for (int s = 0; s < SECTIONS; s++) begin
            if (i_cmd.sect == t_sect'(s)) begin
                h1_sel = r_h1[s];
                h2_sel = r_h2[s];
            end
        end
        unique case (i_cmd.sect)
            2'd0: begin
                poles_sel = i_coefs.first_poles;
                zeros_sel = i_coefs.first_zeros;
            end
            2'd1: begin
                poles_sel = i_coefs.second_poles;
                zeros_sel = i_coefs.second_zeros;
            end
            default: begin
                poles_sel = '0;
                zeros_sel = '0;
            end
        endcase
        unique case (i_cmd.op)
            OP_GAIN: begin
                mul_a = COEF_W'(r_sample);
                mul_b = i_coefs.gain;
            end
            OP_B1: begin
                mul_a = h1_sel;
                mul_b = poles_sel[PAIR_W-1:COEF_W];
            end
            OP_B2: begin
                mul_a = h2_sel;
                mul_b = poles_sel[COEF_W-1:0];
            end
            OP_A1: begin
                mul_a = h1_sel;
                mul_b = zeros_sel[PAIR_W-1:COEF_W];
            end
            default: begin
                mul_a = h2_sel;
                mul_b = zeros_sel[COEF_W-1:0];
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sample) begin
            r_sample <= i_sample_in;
        end
        if (i_cmd.issue) begin
            r_prod      <= prod;
            r_pend_op   <= i_cmd.op;
            r_pend_sect <= i_cmd.sect;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else begin
            r_pend_valid <= i_cmd.issue;
        end
    end

    // round half up to sample scale, then accumulate
    assign rnd_sum = r_prod + RND_HALF;
    assign rnd_ext = ACC_W'(signed'(rnd_sum[PROD_W-1:Q_SHIFT]));
    assign acc_sat = sat32(r_acc);

    always_comb begin
        unique case (r_pend_op)
            OP_GAIN: begin
                base = '0;
                sub  = 1'b0;
            end
            OP_B1: begin
                base = ACC_W'(acc_sat);
                sub  = 1'b1;
            end
            OP_B2: begin
                base = r_acc;
                sub  = 1'b1;
            end
            OP_A1: begin
                base = ACC_W'(acc_sat);
                sub  = 1'b0;
            end
            default: begin
                base = r_acc;
                sub  = 1'b0;
            end
        endcase
        acc_sum = sub ? (base - rnd_ext) : (base + rnd_ext);
    end

    always_ff @(posedge i_clk) begin
        if (r_pend_valid) begin
            r_acc <= acc_sum;
        end
    end

    // history shift once the new word is known
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SECTIONS; s++) begin
                r_h1[s] <= '0;
                r_h2[s] <= '0;
            end
        end else if (r_pend_valid && (r_pend_op == OP_A1)) begin
            for (int s = 0; s < SECTIONS; s++) begin
                if (r_pend_sect == t_sect'(s)) begin
                    r_h2[s] <= r_h1[s];
                    r_h1[s] <= acc_sat;
                end
            end
        end
    end

    always_comb begin
        if (r_acc > SMP_MAX) begin
            out_clip = SMP_MAX[SAMPLE_BITS-1:0];
        end else if (r_acc < SMP_MIN) begin
            out_clip = SMP_MIN[SAMPLE_BITS-1:0];
        end else begin
            out_clip = r_acc[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= out_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_full = r_out_valid && !i_out_ready;
    assign o_sample_out    = r_out;
    assign o_out_valid     = r_out_valid;

endmodule

// ----- sv/cascaded_biquad_lowpass_unit.sv -----
// Fourth-order low-pass IIR filter: SECTIONS direct form II biquads in cascade.
// Input channel: i_in_valid / o_in_ready with i_sample_in (signed Q1.23).
// Output channel: o_out_valid / i_out_ready with o_sample_out (signed Q1.23,
// saturated). One output sample per input sample, in order.
// Coefficients and gain are written over the APB-style port, 64-bit words at
// byte address 8*i: gain, first poles, first zeros, second poles, second zeros.
// Write them only while no sample is in flight.
// One 32x32 multiplier is shared by all products: 1 + 4*SECTIONS multiplies,
// one issued per cycle, each accumulated in the cycle after its issue.
// After the input transaction the controller issues the multiplies, passes
// through a flush state and a done state, and loads the result into the
// output register; a new sample is taken only once that load has happened.
// The output register holds one finished sample; when the receiver stalls,
// the next sample is computed and then waits until the register is free.
// Synchronous reset clears the filter history, restores gain to 1.0 and zeros
// the coefficients; the block is ready as soon as reset is released.
`timescale 1ns / 1ps

module cascaded_biquad_lowpass_unit #(
    parameter int SECTIONS    = 2,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]  i_sample_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]  o_sample_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cbl_pkg::REG_ADDR_W-1:0] paddr,
    input  logic [cbl_pkg::PAIR_W-1:0]     pwdata,
    output logic [cbl_pkg::PAIR_W-1:0]     prdata,
    output logic                           pready
);
    import cbl_pkg::*;

    t_coefs   coefs;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    cbl_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coefs (coefs)
    );

    cbl_ctrl #(
        .SECTIONS (SECTIONS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cbl_dpath #(
        .SECTIONS    (SECTIONS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_coefs      (coefs),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_sample_in  (i_sample_in),
        .o_sample_out (o_sample_out),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready)
    );

endmodule

// ----- sv/cbl_chk.sv -----
`timescale 1ns / 1ps

module cbl_chk #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic signed [SAMPLE_BITS-1:0] o_sample_out,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic                          pready
);

    // no output straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // one sample in flight: no back-to-back input transactions
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while busy");

    // with no result waiting, none appears in the cycle right after an input transaction
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> !o_out_valid)
        else $error("output too early");

    // stalled output holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sample_out))
        else $error("stalled output changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind cascaded_biquad_lowpass_unit cbl_chk #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_cbl_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_sample_out (o_sample_out),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .pready       (pready)
);

// ----- test/biquad_cascade_checker.sv -----
`timescale 1ns / 1ps

module biquad_cascade_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]  i_sample_in,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic signed [SAMPLE_BITS-1:0]  i_sample_out,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [cbl_pkg::REG_ADDR_W-1:0] i_paddr,
    input  logic [cbl_pkg::PAIR_W-1:0]     i_pwdata,
    input  logic                           i_pready,
    output int                             o_errors,
    output int                             o_pending
);
    import cbl_pkg::*;

    logic [COEF_W-1:0]        gain_q28;
    logic [PAIR_W-1:0]        pole_pair [2];
    logic [PAIR_W-1:0]        zero_pair [2];
    logic signed [COEF_W-1:0] hist [4];
    logic signed [SAMPLE_BITS-1:0] expected_samples [$];
    int mismatch_count = 0;
    int in_flight = 0;

    assign o_errors  = mismatch_count;
    assign o_pending = in_flight;

    function automatic longint clamp32(input longint v);
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end else if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        return v;
    endfunction

    // exact product rounded half up to sample scale
    function automatic longint round_q28(input longint a, input longint b);
        longint p;
        p = a * b + (64'sd1 <<< (Q_SHIFT - 1));
        return p >>> Q_SHIFT;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] filter_sample(
        input logic signed [SAMPLE_BITS-1:0] x
    );
        longint acc, w, h1, h2, b1, b2, a1, a2, lim;
        lim = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
        acc = clamp32(round_q28(longint'(x), longint'($signed(gain_q28))));
        for (int s = 0; s < 2; s++) begin
            b1 = $signed(pole_pair[s][PAIR_W-1:COEF_W]);
            b2 = $signed(pole_pair[s][COEF_W-1:0]);
            a1 = $signed(zero_pair[s][PAIR_W-1:COEF_W]);
            a2 = $signed(zero_pair[s][COEF_W-1:0]);
            h1 = hist[2*s];
            h2 = hist[2*s+1];
            w = clamp32(acc - round_q28(h1, b1) - round_q28(h2, b2));
            acc = clamp32(w + round_q28(h1, a1) + round_q28(h2, a2));
            hist[2*s+1] = h1[COEF_W-1:0];
            hist[2*s]   = w[COEF_W-1:0];
        end
        if (acc > lim) begin
            acc = lim;
        end else if (acc < -lim - 1) begin
            acc = -lim - 1;
        end
        return acc[SAMPLE_BITS-1:0];
    endfunction

    always @(posedge i_clk) begin : watch
        logic [REG_IDX_W-1:0] reg_idx;
        logic signed [SAMPLE_BITS-1:0] want;
        if (!i_rst_n) begin
            gain_q28 = GAIN_RESET;
            for (int s = 0; s < 2; s++) begin
                pole_pair[s] = '0;
                zero_pair[s] = '0;
            end
            for (int j = 0; j < 4; j++) begin
                hist[j] = '0;
            end
            expected_samples.delete();
            in_flight = 0;
        end else begin
            reg_idx = i_paddr[REG_ADDR_W-1:REG_ADDR_W-REG_IDX_W];
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (reg_idx)
                    REG_GAIN:         gain_q28 = i_pwdata[COEF_W-1:0];
                    REG_FIRST_POLES:  pole_pair[0] = i_pwdata;
                    REG_FIRST_ZEROS:  zero_pair[0] = i_pwdata;
                    REG_SECOND_POLES: pole_pair[1] = i_pwdata;
                    REG_SECOND_ZEROS: zero_pair[1] = i_pwdata;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_samples.push_back(filter_sample(i_sample_in));
                in_flight++;
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t unexpected sample_out transaction: expected none, actual %0d",
                             $time, i_sample_out);
                    mismatch_count++;
                end else begin
                    want = expected_samples.pop_front();
                    in_flight--;
                    if (i_sample_out !== want) begin
                        $display("%0t sample_out mismatch: expected %0d, actual %0d",
                                 $time, want, i_sample_out);
                        mismatch_count++;
                    end
                end
            end
        end
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import cbl_pkg::*;

    localparam int SAMPLE_BITS = 24;
    localparam int RANDOM_ITEMS = 1250;
    localparam int LONG_HOLD = 400;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam real TWO_PI = 6.283185307179586;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd5;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7fffff;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh800000;

    localparam int RX_STEADY   = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_PERIODIC = 2;

    localparam int CFG_BUTTERWORTH = 0;
    localparam int CFG_WILD        = 1;
    localparam int CFG_MODEST      = 2;
    localparam int CFG_ZEROS_ONLY  = 3;
    localparam int CFG_EXTREMES    = 4;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic signed [SAMPLE_BITS-1:0] i_sample_in;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic signed [SAMPLE_BITS-1:0] o_sample_out;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [REG_ADDR_W-1:0]         paddr;
    logic [PAIR_W-1:0]             pwdata;
    logic [PAIR_W-1:0]             prdata;
    logic                          pready;

    int  errors;
    int  pending;
    int  cycles = 0;
    bit  hold_off_req = 1'b0;

    cascaded_biquad_lowpass_unit #(
        .SECTIONS(2),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_sample_in(i_sample_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_sample_out(o_sample_out),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    biquad_cascade_checker #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) i_check (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_ready(o_in_ready),
        .i_sample_in(i_sample_in),
        .i_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_sample_out(o_sample_out),
        .i_psel(psel),
        .i_penable(penable),
        .i_pwrite(pwrite),
        .i_paddr(paddr),
        .i_pwdata(pwdata),
        .i_pready(pready),
        .o_errors(errors),
        .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [COEF_W-1:0] to_q28(input real r);
        return COEF_W'($rtoi(r * 268435456.0));
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 6))
            0: return 32'h0000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3: return 32'hffff_ffff;
            4: return 32'h0000_0001;
            5: return 32'h1000_0000;
            default: return $urandom;
        endcase
    endfunction

    // within +-1.0
    function automatic logic [COEF_W-1:0] modest_coef();
        return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] next_sample(
        input logic signed [SAMPLE_BITS-1:0] prev
    );
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return SAMPLE_BITS'($urandom);
            5, 6: return SAMPLE_BITS'($urandom_range(0, 511) - 256);
            7: return SAMPLE_MAX;
            8: return SAMPLE_MIN;
            default: return prev;
        endcase
    endfunction

    task automatic design_section(input real f, input real q,
                                  output logic [PAIR_W-1:0] poles,
                                  output logic [PAIR_W-1:0] zeros,
                                  output real k);
        real w0, cw, al, a0;
        w0 = TWO_PI * f;
        cw = $cos(w0);
        al = $sin(w0) / (2.0 * q);
        a0 = 1.0 + al;
        poles = {to_q28(-2.0 * cw / a0), to_q28((1.0 - al) / a0)};
        zeros = {to_q28(2.0), to_q28(1.0)};
        k = (1.0 - cw) / (2.0 * a0);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PAIR_W-1:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 3'b000};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic load_filter(input logic [COEF_W-1:0] g,
                               input logic [PAIR_W-1:0] p1, input logic [PAIR_W-1:0] z1,
                               input logic [PAIR_W-1:0] p2, input logic [PAIR_W-1:0] z2);
        wait_idle();
        write_reg(REG_GAIN, {$urandom, g});
        write_reg(REG_FIRST_POLES, p1);
        write_reg(REG_FIRST_ZEROS, z1);
        write_reg(REG_SECOND_POLES, p2);
        write_reg(REG_SECOND_ZEROS, z2);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x);
        i_in_valid = 1'b1;
        i_sample_in = x;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic run_samples(input int count, input bit with_gaps);
        int burst;
        logic signed [SAMPLE_BITS-1:0] x;
        burst = $urandom_range(1, 16);
        x = '0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                if (with_gaps) begin
                    i_in_valid = 1'b0;
                    repeat ($urandom_range(1, 10)) @(negedge i_clk);
                end
                burst = $urandom_range(1, 16);
            end
            x = next_sample(x);
            send_sample(x);
            burst--;
        end
    endtask

    // receiver stall pattern
    initial begin : out_side
        int mode, span, k;
        bit held;
        held = 1'b0;
        i_out_ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_off_req && !held) begin
                held = 1'b1;
                i_out_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end
            mode = $urandom_range(RX_STEADY, RX_PERIODIC);
            span = $urandom_range(5, 60);
            k = $urandom_range(2, 6);
            for (int c = 0; c < span; c++) begin
                case (mode)
                    RX_STEADY:   i_out_ready = 1'b1;
                    RX_RANDOM:   i_out_ready = 1'($urandom);
                    default:     i_out_ready = (c % k == 0);
                endcase
                @(negedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int sent, count;
        real f, k1, k2;
        logic [COEF_W-1:0] g;
        logic [PAIR_W-1:0] p1, z1, p2, z2;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_sample_in = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // defaults after reset: unity gain, empty sections
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(24'sd0);
        send_sample(24'sd1);
        send_sample(-24'sd1);
        send_sample(24'sh555555);
        send_sample(24'shaaaaaa);

        // largest gains, output clipping
        load_filter(32'h7fff_ffff, '0, '0, '0, '0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(24'sd1000);
        load_filter(32'h8000_0000, '0, '0, '0, '0);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);

        // extreme coefficients drive the histories into saturation
        load_filter(32'h1000_0000, 64'h8000_0000_8000_0000, 64'h7fff_ffff_7fff_ffff,
                    64'h7fff_ffff_8000_0000, 64'hffff_ffff_0000_0001);
        write_reg(REG_UNUSED, {$urandom, $urandom});
        repeat (4) send_sample(SAMPLE_MAX);
        repeat (4) send_sample(SAMPLE_MIN);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(CFG_BUTTERWORTH, CFG_EXTREMES))
                CFG_BUTTERWORTH: begin
                    f = 0.03 + 0.42 * ($urandom_range(0, 1000) / 1000.0);
                    design_section(f, 0.5412, p1, z1, k1);
                    design_section(f, 1.3066, p2, z2, k2);
                    g = to_q28(k1 * k2 * (0.5 + $urandom_range(0, 100) / 100.0));
                end
                CFG_WILD: begin
                    g = $urandom;
                    p1 = {$urandom, $urandom};
                    z1 = {$urandom, $urandom};
                    p2 = {$urandom, $urandom};
                    z2 = {$urandom, $urandom};
                end
                CFG_MODEST: begin
                    g = modest_coef();
                    p1 = {modest_coef(), modest_coef()};
                    z1 = {modest_coef(), modest_coef()};
                    p2 = {modest_coef(), modest_coef()};
                    z2 = {modest_coef(), modest_coef()};
                end
                CFG_ZEROS_ONLY: begin
                    g = modest_coef();
                    p1 = '0;
                    p2 = '0;
                    z1 = {$urandom, $urandom};
                    z2 = {modest_coef(), modest_coef()};
                end
                default: begin
                    g = pick_coef();
                    p1 = {pick_coef(), pick_coef()};
                    z1 = {pick_coef(), pick_coef()};
                    p2 = {pick_coef(), pick_coef()};
                    z2 = {pick_coef(), pick_coef()};
                end
            endcase
            load_filter(g, p1, z1, p2, z2);
            // the first request starts the single long receiver stall, while samples are being offered
            hold_off_req = 1'b1;
            count = $urandom_range(30, 110);
            run_samples(count, $urandom_range(0, 3) != 0);
            sent += count;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
